@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the sieve block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pso_pkg.sv @@
// Package with constants, types and helper functions of the odd-only sieve.
`default_nettype none

package pso_pkg;

  localparam int unsigned MAX_VALUE   = 65535;
  localparam int unsigned STORE_DEPTH = 32768;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned LIM_W       = 16;
  localparam int unsigned VAL_W       = LIM_W + 2;
  localparam int unsigned I_W         = LIM_W / 2 + 2;
  localparam int unsigned STORE_CAP   = 2 * STORE_DEPTH - 1;
  localparam int unsigned LIMIT_CAP   = (MAX_VALUE < STORE_CAP) ? MAX_VALUE : STORE_CAP;
  localparam int unsigned SMALL_LIMIT = 7;
  localparam int unsigned FIRST_ODD   = 3;

  localparam logic [0:0] REQ_BUILD  = 1'b0;
  localparam logic [0:0] REQ_QUERY  = 1'b1;
  localparam logic [0:0] RESP_BUILD = 1'b0;
  localparam logic [0:0] RESP_QUERY = 1'b1;

  localparam logic [0:0] REG_UPPER_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_CHECK,
    ST_TEST,
    ST_CLEAR,
    ST_DONE,
    ST_QRESP
  } pso_state_t;

  typedef struct packed {
    logic fill_step;
    logic sieve_init;
    logic rd_i;
    logic clr_start;
    logic clr_step;
    logic i_next;
    logic q_read;
    logic load_build;
    logic load_query;
  } pso_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic lim_gt_small;
    logic sq_gt_lim;
    logic j_gt_lim;
    logic rd_bit;
    logic out_free;
  } pso_stat_t;

  function automatic logic [ADDR_W-1:0] bit_index(input logic [VAL_W-1:0] n);
    return n[ADDR_W:1];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pso_ctrl.sv @@
// Controller state machine that sequences the fill, sieve and query steps.
`default_nettype none

module pso_ctrl
  import pso_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_req,
  output logic           in_ready,
  input  wire pso_stat_t stat,
  output pso_cmd_t       cmd
);

  pso_state_t state;
  pso_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_req == REQ_QUERY) ? ST_QRESP : ST_FILL;
        end
      end
      ST_FILL: begin
        if (stat.fill_last) state_next = stat.lim_gt_small ? ST_CHECK : ST_DONE;
      end
      ST_CHECK: begin
        state_next = stat.sq_gt_lim ? ST_DONE : ST_TEST;
      end
      ST_TEST: begin
        state_next = stat.rd_bit ? ST_CLEAR : ST_CHECK;
      end
      ST_CLEAR: begin
        if (stat.j_gt_lim) state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_QRESP: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.q_read = in_valid && (in_req == REQ_QUERY);
      end
      ST_FILL: begin
        cmd.fill_step  = 1'b1;
        cmd.sieve_init = stat.fill_last;
      end
      ST_CHECK: begin
        cmd.rd_i = !stat.sq_gt_lim;
      end
      ST_TEST: begin
        cmd.clr_start = stat.rd_bit;
        cmd.i_next    = !stat.rd_bit;
      end
      ST_CLEAR: begin
        cmd.clr_step = !stat.j_gt_lim;
        cmd.i_next   = stat.j_gt_lim;
      end
      ST_DONE: begin
        cmd.load_build = stat.out_free;
      end
      ST_QRESP: begin
        cmd.load_query = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/pso_dp.sv @@
// Datapath with the one-bit sieve store, the sieve counters and the result register.
`default_nettype none

module pso_dp
  import pso_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pso_cmd_t         cmd,
  output pso_stat_t             stat,
  input  wire logic [LIM_W-1:0] lim,
  input  wire logic [LIM_W-1:0] query_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_kind,
  output logic                  out_prime,
  output logic                  out_oor
);

  logic              store [STORE_DEPTH];
  logic [ADDR_W-1:0] fill_cnt;
  logic [I_W-1:0]    i;
  logic [VAL_W-1:0]  sq;
  logic [VAL_W-1:0]  j;
  logic [VAL_W-1:0]  stride;
  logic [LIM_W-1:0]  qv;
  logic              rd_bit;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic              wbit;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [VAL_W-1:0]  lim_ext;
  logic              q_oor;
  logic              q_prime;

  assign lim_ext = VAL_W'(lim);

  always_comb begin
    we    = cmd.fill_step || cmd.clr_step;
    waddr = cmd.fill_step ? fill_cnt : bit_index(j);
    wbit  = cmd.fill_step;
    re    = cmd.rd_i || cmd.q_read;
    raddr = cmd.q_read ? bit_index(VAL_W'(query_value)) : bit_index(VAL_W'(i));
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wbit;
    if (re) rd_bit <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (cmd.fill_step) begin
      fill_cnt <= stat.fill_last ? '0 : fill_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sieve_init) begin
      i  <= I_W'(FIRST_ODD);
      sq <= VAL_W'(FIRST_ODD * FIRST_ODD);
    end else if (cmd.i_next) begin
      i  <= i + I_W'(2);
      sq <= sq + VAL_W'({i, 2'b00}) + VAL_W'(4);
    end
    if (cmd.clr_start) begin
      j      <= sq;
      stride <= VAL_W'({i, 1'b0});
    end else if (cmd.clr_step) begin
      j <= j + stride;
    end
    if (cmd.q_read) qv <= query_value;
  end

  always_comb begin
    q_oor   = qv > lim;
    q_prime = !q_oor && ((qv == LIM_W'(2)) || (qv[0] && (qv != LIM_W'(1)) && rd_bit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_build || cmd.load_query) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_build) begin
      out_kind  <= RESP_BUILD;
      out_prime <= 1'b0;
      out_oor   <= 1'b0;
    end else if (cmd.load_query) begin
      out_kind  <= RESP_QUERY;
      out_prime <= q_prime;
      out_oor   <= q_oor;
    end
  end

  always_comb begin
    stat.fill_last    = fill_cnt == ADDR_W'(STORE_DEPTH - 1);
    stat.lim_gt_small = lim > LIM_W'(SMALL_LIMIT);
    stat.sq_gt_lim    = sq > lim_ext;
    stat.j_gt_lim     = j > lim_ext;
    stat.rd_bit       = rd_bit;
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

@@ rtl/core/prime_sieve_odd_only_unit.sv @@
// Top level of the odd-only prime sieve: register port, controller and datapath.
//
// Channel  Direction  Content
// s_axis   in         tdata = query_value[15:0], tuser = req_type
// m_axis   out        tdata = is_prime, out_of_range, zero pad; tuser = resp_kind
// apb      in/out     upper_limit at byte address 0
//
// A query passes through a registered store read and then the result register.
// A build sweeps every store entry back to prime; above a limit of 7 each odd i with
// i*i <= limit is then checked and its bit tested, an i still marked prime clears each odd
// multiple from i*i up to the limit, and a last check precedes loading the build result.
// After reset a fill sweep over all 32768 store entries runs before the first transfer is taken.
// A new result waits in its result state while the previous one still waits on m_tready.
`default_nettype none

`include "assert_macros.svh"

module prime_sieve_odd_only_unit
  import pso_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // query_value[15:0]
  input  wire logic        s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // is_prime, out_of_range, six zero bits
  output logic             m_tuser,   // resp_kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [LIM_W-1:0] upper_limit;
  logic [LIM_W-1:0] lim;
  pso_cmd_t         cmd;
  pso_stat_t        stat;
  logic             out_prime;
  logic             out_oor;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= LIM_W'(65535);
    end else if (psel && penable && pwrite && (paddr[2] == REG_UPPER_LIMIT)) begin
      upper_limit <= pwdata[LIM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_UPPER_LIMIT) ? {16'b0, upper_limit} : 32'b0;

  assign lim = ({16'b0, upper_limit} > 32'(LIMIT_CAP)) ? LIM_W'(LIMIT_CAP) : upper_limit;

  pso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pso_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .lim         (lim),
    .query_value (s_tdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_prime   (out_prime),
    .out_oor     (out_oor)
  );

  assign m_tdata = {6'b0, out_oor, out_prime};

  `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `ASSERT_IMPL(a_prime_on_query, m_tvalid && m_tdata[0], m_tuser, "prime flag on build")
  `ASSERT_IMPL(a_prime_in_range, m_tvalid && m_tdata[0], !m_tdata[1], "prime and out of range")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the odd-only prime sieve unit, built on a bit-level predictor.
module testbench;
  import pso_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 5_000_000;
  localparam int unsigned PHASES            = 9;
  localparam int unsigned QUERIES_PER_PHASE = 160;
  localparam int unsigned PLAN_ROWS         = 30;

  typedef enum logic [1:0] {
    ACT_BUILD,
    ACT_QUERY,
    ACT_LIMIT
  } action_t;

  typedef struct packed {
    action_t     act;
    logic [15:0] value;
    logic        typed;
    logic        prime;
    logic        oor;
  } plan_row_t;

  typedef struct packed {
    logic kind;
    logic prime;
    logic oor;
  } answer_t;

  // Rows with typed set carry a fixed expected answer; the rest use the predictor.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ACT_QUERY, 16'd0,     1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd1,     1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd2,     1'b1, 1'b1, 1'b0},
    '{ACT_QUERY, 16'd9,     1'b1, 1'b1, 1'b0},
    '{ACT_QUERY, 16'd65535, 1'b1, 1'b1, 1'b0},
    '{ACT_QUERY, 16'd65534, 1'b1, 1'b0, 1'b0},
    '{ACT_BUILD, 16'hA5C3,  1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd9,     1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd65521, 1'b0, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd65535, 1'b0, 1'b0, 1'b0},
    '{ACT_LIMIT, 16'd7,     1'b0, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd8,     1'b1, 1'b0, 1'b1},
    '{ACT_QUERY, 16'd9,     1'b1, 1'b0, 1'b1},
    '{ACT_QUERY, 16'd65535, 1'b1, 1'b0, 1'b1},
    '{ACT_BUILD, 16'hFFFF,  1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd7,     1'b1, 1'b1, 1'b0},
    '{ACT_QUERY, 16'd5,     1'b0, 1'b0, 1'b0},
    '{ACT_LIMIT, 16'd100,   1'b0, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd99,    1'b0, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd101,   1'b1, 1'b0, 1'b1},
    '{ACT_BUILD, 16'h0000,  1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd99,    1'b0, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd97,    1'b0, 1'b0, 1'b0},
    '{ACT_LIMIT, 16'd0,     1'b0, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd0,     1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd1,     1'b1, 1'b0, 1'b1},
    '{ACT_BUILD, 16'h5A3C,  1'b1, 1'b0, 1'b0},
    '{ACT_LIMIT, 16'd8,     1'b0, 1'b0, 1'b0},
    '{ACT_BUILD, 16'h0F0F,  1'b1, 1'b0, 1'b0},
    '{ACT_QUERY, 16'd9,     1'b0, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // query_value[15:0]
  logic        s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;   // is_prime, out_of_range, six zero bits
  logic        m_tuser;   // resp_kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        steady = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  bit          sieve_bits [STORE_DEPTH];
  logic [15:0] limit_reg;
  answer_t     pending_answers [$];

  prime_sieve_odd_only_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned sieve_limit();
    int unsigned lim;
    lim = limit_reg;
    if (lim > MAX_VALUE) lim = MAX_VALUE;
    if (lim > 2 * STORE_DEPTH - 1) lim = 2 * STORE_DEPTH - 1;
    return lim;
  endfunction

  function automatic void rebuild_sieve();
    int unsigned lim;
    int unsigned i;
    int unsigned j;
    lim = sieve_limit();
    foreach (sieve_bits[k]) sieve_bits[k] = 1'b1;
    if (lim > SMALL_LIMIT) begin
      for (i = 3; i * i <= lim; i += 2) begin
        if (sieve_bits[(i >> 1) % STORE_DEPTH]) begin
          for (j = i * i; j <= lim; j += 2 * i) sieve_bits[(j >> 1) % STORE_DEPTH] = 1'b0;
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(input action_t act, input logic [15:0] v);
    answer_t a;
    a = '0;
    if (act == ACT_BUILD) begin
      rebuild_sieve();
      a.kind = RESP_BUILD;
      return a;
    end
    a.kind = RESP_QUERY;
    if (v > sieve_limit()) begin
      a.oor = 1'b1;
    end else if (v == 16'd2) begin
      a.prime = 1'b1;
    end else if (v > 16'd2 && v[0]) begin
      a.prime = sieve_bits[v >> 1];
    end
    return a;
  endfunction

  function automatic logic [15:0] pick_query(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 5) return 16'($urandom_range(0, lim));
    if (r == 6 && lim < 65535) return 16'($urandom_range(lim + 1, 65535));
    if (r == 8) return 16'($urandom_range(0, 20));
    if (r == 9) return 16'(lim - $urandom_range(0, (lim < 4) ? lim : 4));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic transfer_request(input action_t act, input logic [15:0] v, input logic typed,
                                  input answer_t typed_answer);
    answer_t a;
    while (!steady && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= (act == ACT_QUERY) ? REQ_QUERY : REQ_BUILD;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    a = predict_answer(act, v);
    pending_answers.push_back(typed ? typed_answer : a);
  endtask

  task automatic await_answers();
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_upper_limit(input logic [15:0] value);
    await_answers();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_UPPER_LIMIT, 2'b00};
    pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_reg = value;
  endtask

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin : check_answer
    answer_t exp_answer;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result kind=%0d prime=%0d oor=%0d",
                   m_tuser, m_tdata[0], m_tdata[1]);
      end else begin
        exp_answer = pending_answers.pop_front();
        if (m_tuser !== exp_answer.kind || m_tdata[0] !== exp_answer.prime ||
            m_tdata[1] !== exp_answer.oor) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected kind=%0d prime=%0d oor=%0d, got kind=%0d prime=%0d oor=%0d",
                     exp_answer.kind, exp_answer.prime, exp_answer.oor,
                     m_tuser, m_tdata[0], m_tdata[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned lim;
    int unsigned ph;
    int unsigned n;
    int unsigned k;
    answer_t     typed_answer;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= 1'b0;
    s_tdata  <= 16'h0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    limit_reg = 16'hFFFF;
    foreach (sieve_bits[b]) sieve_bits[b] = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < PLAN_ROWS; k++) begin
      if (PLAN[k].act == ACT_LIMIT) begin
        write_upper_limit(PLAN[k].value);
      end else begin
        typed_answer = '{kind: PLAN[k].act == ACT_QUERY, prime: PLAN[k].prime, oor: PLAN[k].oor};
        transfer_request(PLAN[k].act, PLAN[k].value, PLAN[k].typed, typed_answer);
      end
    end

    // Phases without a build read a store built under another limit.
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) lim = 65535;
      else if (ph == 1) lim = 8;
      else if (ph == 2) lim = $urandom_range(0, 7);
      else if ($urandom_range(0, 1) == 1) lim = $urandom_range(9, 2047);
      else lim = $urandom_range(2048, 65535);
      write_upper_limit(16'(lim));
      steady = (ph == 4);
      if (ph != 3 && ph != 7)
        transfer_request(ACT_BUILD, 16'($urandom_range(0, 65535)), 1'b0, '0);
      for (n = 0; n < QUERIES_PER_PHASE; n++) begin
        if (n == QUERIES_PER_PHASE / 2 || $urandom_range(0, 99) == 0) await_answers();
        transfer_request(ACT_QUERY, pick_query(lim), 1'b0, '0);
      end
    end
    steady = 1'b0;

    await_answers();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
